### hdl/mbid_pkg.sv
// Shared constants and control types for the multi-bitmap intersect decoder.
// No dependencies; every other file of the block refers to this package.
package mbid_pkg;

    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int WIDX_W      = WORD_W - BIT_W;
    localparam int BYTE_W      = 8;
    localparam int BYTE_SEL_W  = 3;
    localparam int LEAD_W      = 3;

    localparam int MAX_MAPS    = 16;
    localparam int MAP_COUNT_W = 5;
    localparam int MAP_CNT_W   = $clog2(MAX_MAPS + 1);
    localparam int CMP_W       = (MAP_CNT_W > MAP_COUNT_W) ? MAP_CNT_W : MAP_COUNT_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE = CFG_IDX_W'(1);

    localparam logic [MAP_COUNT_W-1:0] MAP_COUNT_RST = MAP_COUNT_W'(2);

    typedef struct packed {
        logic                  in_ready;
        logic                  first;
        logic                  close;
        logic                  restart;
        logic                  emit;
        logic [BYTE_SEL_W-1:0] byte_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                 in_valid;
        logic                 in_last;
        logic [MAP_CNT_W-1:0] eff_maps;
        logic                 close_zero;
        logic                 byte_hit;
        logic                 rest_zero;
        logic                 out_free;
    } dp_status_t;

endpackage

### hdl/mbid_in_if.sv
// Input channel of the intersect decoder: one bitmap word and its run-end flag.
// Depends on mbid_pkg for the word width.
interface mbid_in_if;
    logic                        valid;
    logic                        ready;
    logic [mbid_pkg::WORD_W-1:0] word;
    logic                        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink (input valid, input word, input last_word, output ready);
endinterface

### hdl/mbid_out_if.sv
// Output channel of the intersect decoder: one decoded value and its end flag.
// Depends on mbid_pkg for the word width.
interface mbid_out_if;
    logic                        valid;
    logic                        ready;
    logic [mbid_pkg::WORD_W-1:0] value;
    logic                        last_of_word;

    modport source (output valid, output value, output last_of_word, input ready);
    modport sink (input valid, input value, input last_of_word, output ready);
endinterface

### hdl/mbid_ctrl.sv
// Sequencer of the intersect decoder: map counting, position close and byte scan.
// Depends on mbid_pkg for the command and status types.
module mbid_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbid_pkg::dp_status_t status,
    output mbid_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_DECODE = 1'b1;

    logic                            state_reg;
    logic                            state_next;
    logic [mbid_pkg::MAP_CNT_W-1:0]  map_cnt_reg;
    logic [mbid_pkg::MAP_CNT_W-1:0]  map_cnt_next;
    logic [mbid_pkg::BYTE_SEL_W-1:0] byte_idx_reg;
    logic [mbid_pkg::BYTE_SEL_W-1:0] byte_idx_next;
    logic [mbid_pkg::MAP_CNT_W-1:0]  cnt_inc;
    logic                            take;
    logic                            close;

    always_comb
    begin
        cnt_inc = map_cnt_reg + mbid_pkg::MAP_CNT_W'(1);
        take    = status.in_valid && (state_reg == ST_ACCEPT);
        close   = take && ((cnt_inc >= status.eff_maps) || status.in_last);

        state_next    = state_reg;
        map_cnt_next  = map_cnt_reg;
        byte_idx_next = byte_idx_reg;

        cmd.in_ready = (state_reg == ST_ACCEPT);
        cmd.first    = (map_cnt_reg == '0);
        cmd.close    = close;
        cmd.restart  = status.in_last;
        cmd.emit     = 1'b0;
        cmd.byte_sel = byte_idx_reg;

        case (state_reg)
            ST_ACCEPT:
            begin
                if (take)
                begin
                    if (close)
                    begin
                        map_cnt_next  = '0;
                        byte_idx_next = '0;
                        if (!status.close_zero)
                        begin
                            state_next = ST_DECODE;
                        end
                    end
                    else
                    begin
                        map_cnt_next = cnt_inc;
                    end
                end
            end
            ST_DECODE:
            begin
                if (status.out_free)
                begin
                    if (status.byte_hit)
                    begin
                        cmd.emit = 1'b1;
                        if (status.rest_zero)
                        begin
                            state_next = ST_ACCEPT;
                        end
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + mbid_pkg::BYTE_SEL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ACCEPT;
            map_cnt_reg  <= '0;
            byte_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            map_cnt_reg  <= map_cnt_next;
            byte_idx_reg <= byte_idx_next;
        end
    end

endmodule

### hdl/mbid_dp.sv
// Datapath of the intersect decoder: config registers, AND accumulator,
// decode word, byte-wise leading-one search and output register.
// Depends on mbid_pkg and on the mbid_in_if / mbid_out_if interfaces.
module mbid_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mbid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbid_pkg::CFG_DATA_W-1:0]     cfg_data,
    mbid_in_if.sink                             in_ch,
    mbid_out_if.source                          out_ch,
    input  mbid_pkg::ctrl_cmd_t                 cmd,
    output mbid_pkg::dp_status_t                status
);

    logic [mbid_pkg::MAP_COUNT_W-1:0] map_count_reg;
    logic [mbid_pkg::WORD_W-1:0]      base_reg;
    logic [mbid_pkg::WORD_W-1:0]      acc_reg;
    logic [mbid_pkg::WORD_W-1:0]      acc_next;
    logic [mbid_pkg::WIDX_W-1:0]      widx_reg;
    logic [mbid_pkg::WORD_W-1:0]      bits_reg;
    logic [mbid_pkg::WORD_W-1:0]      bits_clr;
    logic [mbid_pkg::WORD_W-1:0]      offset_reg;
    logic                             out_valid_reg;
    logic [mbid_pkg::WORD_W-1:0]      out_value_reg;
    logic                             out_last_reg;

    logic                             take;
    logic [mbid_pkg::CMP_W-1:0]       count_ext;
    logic [mbid_pkg::MAP_CNT_W-1:0]   eff;
    logic [mbid_pkg::BYTE_W-1:0]      cur_byte;
    logic [mbid_pkg::LEAD_W-1:0]      lead;
    logic [mbid_pkg::BIT_W-1:0]       bit_pos;
    logic [mbid_pkg::BIT_W-1:0]       delta;

    assign take      = in_ch.valid && cmd.in_ready;
    assign in_ch.ready = cmd.in_ready;

    // Effective map count: zero acts as one, anything above the maximum is clamped.
    always_comb
    begin
        count_ext = mbid_pkg::CMP_W'(map_count_reg);
        if (map_count_reg == '0)
        begin
            eff = mbid_pkg::MAP_CNT_W'(1);
        end
        else if (count_ext > mbid_pkg::CMP_W'(mbid_pkg::MAX_MAPS))
        begin
            eff = mbid_pkg::MAP_CNT_W'(mbid_pkg::MAX_MAPS);
        end
        else
        begin
            eff = mbid_pkg::MAP_CNT_W'(count_ext);
        end
    end

    assign acc_next = cmd.first ? in_ch.word : (acc_reg & in_ch.word);

    // Bytes are scanned from the most significant one, since bit 63 is offset 0.
    always_comb
    begin
        cur_byte = bits_reg[{~cmd.byte_sel, 3'b000} +: mbid_pkg::BYTE_W];
        lead     = '0;
        for (int i = 0; i < mbid_pkg::BYTE_W; i++)
        begin
            if (cur_byte[i])
            begin
                lead = mbid_pkg::LEAD_W'(i);
            end
        end
        bit_pos  = {~cmd.byte_sel, lead};
        delta    = {cmd.byte_sel, ~lead};
        bits_clr = bits_reg & ~(mbid_pkg::WORD_W'(1) << bit_pos);
    end

    always_comb
    begin
        status.in_valid   = in_ch.valid;
        status.in_last    = in_ch.last_word;
        status.eff_maps   = eff;
        status.close_zero = (acc_next == '0);
        status.byte_hit   = (cur_byte != '0);
        status.rest_zero  = (bits_clr == '0);
        status.out_free   = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_count_reg <= mbid_pkg::MAP_COUNT_RST;
            base_reg      <= '0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == mbid_pkg::REG_MAP_COUNT))
            begin
                map_count_reg <= cfg_data[mbid_pkg::MAP_COUNT_W-1:0];
            end
            if (cfg_write && (cfg_index == mbid_pkg::REG_BASE_VALUE))
            begin
                base_reg <= cfg_data[mbid_pkg::WORD_W-1:0];
            end
            if (cmd.close)
            begin
                widx_reg <= cmd.restart ? '0 : widx_reg + mbid_pkg::WIDX_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.close)
        begin
            bits_reg   <= acc_next;
            offset_reg <= base_reg + {widx_reg, {mbid_pkg::BIT_W{1'b0}}};
        end
        else if (cmd.emit)
        begin
            bits_reg <= bits_clr;
        end
        if (cmd.emit)
        begin
            out_value_reg <= offset_reg + mbid_pkg::WORD_W'(delta);
            out_last_reg  <= (bits_clr == '0);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.value        = out_value_reg;
    assign out_ch.last_of_word = out_last_reg;

endmodule

### hdl/multi_bitmap_intersect_decode.sv
// Top level of the multi-bitmap intersect decoder.
// Depends on mbid_pkg, mbid_in_if, mbid_out_if, mbid_ctrl and mbid_dp.

// The block takes bitmap words one per cycle, all maps of one word position
// in map order, and ANDs them; when the position closes (the configured map
// count is reached, or last_word is seen) it decodes the surviving bits into
// values base_value + word_index*64 + offset, where bit 63 of a word is
// offset 0, emitting them in ascending order with last_of_word on the final
// one. A closed position with a nonzero intersection holds the input for its
// decode, which scans the 64-bit result a byte at a time from the top byte:
// it emits one value per set bit and steps past each byte ahead of the byte
// that holds the last set bit, whether that byte was zero from the start or
// has just been emptied, and it waits while the output is stalled.
// A position whose intersection is zero is not decoded and does not hold
// the input. The decode rate is set by the byte-scan sequencer in
// mbid_ctrl and the single output register in mbid_dp, which lets the sink
// stall without losing a value. Configuration is written through cfg_write,
// cfg_index and cfg_data: index 0 is map_count from cfg_data[4:0] (reset 2,
// zero acts as one, 17 to 31 act as 16), index 1 is base_value (reset 0);
// other indexes are ignored. Write configuration only while the block is idle.
module multi_bitmap_intersect_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [mbid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbid_pkg::CFG_DATA_W-1:0] cfg_data,
    mbid_in_if.sink                         in_ch,
    mbid_out_if.source                      out_ch
);

    // Commands from the sequencer into the datapath, status back the other way.
    mbid_pkg::ctrl_cmd_t  cmd;
    mbid_pkg::dp_status_t status;

    mbid_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath owns both channels: it drives ready from the sequencer's
    // command and presents every decoded value from its output register.
    mbid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
